// File: hdl/knps_pkg.sv
// ----------------------------------------------------------------------------
// knps_pkg: shared constants and types for the k nearest point selector
// Field widths, store depth, and the command and status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package knps_pkg;

    // store depth and derived widths
    localparam int MAX_NEIGHBORS = 16;
    localparam int CNT_W         = $clog2(MAX_NEIGHBORS + 1);
    localparam int IDX_W         = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;

    // field widths
    localparam int ID_W    = 32;
    localparam int DIST_W  = 32;
    localparam int CFG_W   = 5;
    localparam int TDATA_W = ID_W + DIST_W;

    // neighbor_count after reset
    localparam logic [CFG_W-1:0] K_RESET = CFG_W'(16);

    // operation codes carried on s_tuser
    localparam logic OP_OFFER  = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic compare;     // register per-cell compare flags
        logic update;      // apply insert or replace
        logic emit_entry;  // move head cell to output and shift the list down
        logic emit_empty;  // load the empty marker result
    } knps_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic held_zero;   // nothing held
        logic held_one;    // exactly one entry left
        logic out_free;    // output register can take a result
    } knps_stat_t;

endpackage

// File: hdl/k_nearest_point_select.sv
// ----------------------------------------------------------------------------
// k_nearest_point_select: keeps the k nearest candidates of one query
// Offer items update a sorted store of up to 16 entries; a finish item
// streams the store out in ascending distance and clears it.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser is the operation (0 offer, 1 finish), s_tdata
//   carries point id and distance. Output stream m_*: one item per held
//   entry in ascending distance, ties in arrival order, m_tlast on the final
//   one; a finish with nothing held gives one item with m_tuser set.
//   cfg_we/cfg_wdata write neighbor_count (0 acts as 1, above 16 as 16);
//   write it only while the block is idle.
// Sequence:
//   An offer runs accept, compare of all cells against the item and the
//   largest entry, then the insert-or-replace update of the cells.
//   A finish gives one result per held entry, or one empty marker; they
//   leave one per cycle from the head cell while the output register is
//   free, each set up in the emit state and then held in the output register.
// Reset and stall:
//   Reset clears the count and output valid and sets neighbor_count to 16.
//   When m_tready is low the output register holds its item and emission
//   waits; the next input item can be accepted while the final result of a
//   run still waits in the output register.
// ----------------------------------------------------------------------------
module k_nearest_point_select (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic [knps_pkg::CFG_W-1:0]     cfg_wdata,   // neighbor_count
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [knps_pkg::TDATA_W-1:0]   s_tdata,     // point_id, distance
    input  logic                           s_tuser,     // operation
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [knps_pkg::TDATA_W-1:0]   m_tdata,     // point_id_res, distance_res
    output logic                           m_tlast,
    output logic                           m_tuser      // empty_res
);

    knps_pkg::knps_cmd_t  cmd;
    knps_pkg::knps_stat_t stat;

    // controller
    knps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    knps_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // empty marker always closes its run
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("empty result without last");

    // a finish blocks the input while it emits
    a_finish_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == knps_pkg::OP_FINISH) |=> !s_tready)
        else $error("input accepted during emission");

    // an offer holds the input for its compare and update cycles
    a_offer_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == knps_pkg::OP_OFFER)
        |=> !s_tready ##1 !s_tready)
        else $error("input accepted during offer update");

    // at most one datapath command per cycle
    a_cmd_single: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.capture, cmd.compare, cmd.update, cmd.emit_entry, cmd.emit_empty}))
        else $error("overlapping datapath commands");

endmodule

// File: hdl/knps_datapath.sv
// ----------------------------------------------------------------------------
// knps_datapath: sorted candidate cells, count register and output register
// The cells hold the kept entries sorted by distance, ties in arrival order.
// An offer inserts in place; with the store full, a smaller item evicts the first entry of the largest group.
// ----------------------------------------------------------------------------
module knps_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [knps_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [knps_pkg::TDATA_W-1:0]   s_tdata,
    input  knps_pkg::knps_cmd_t            cmd,
    output knps_pkg::knps_stat_t           stat,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [knps_pkg::TDATA_W-1:0]   m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int MAXN  = knps_pkg::MAX_NEIGHBORS;
    localparam int CNT_W = knps_pkg::CNT_W;
    localparam int IDX_W = knps_pkg::IDX_W;
    localparam int ID_W  = knps_pkg::ID_W;
    localparam int DW    = knps_pkg::DIST_W;

    // configuration and item registers
    logic [knps_pkg::CFG_W-1:0] k_reg;
    logic [ID_W-1:0]            in_id_reg;
    logic [DW-1:0]              in_dist_reg;
    logic [CNT_W-1:0]           held_reg, held_next;

    // candidate cells
    logic [ID_W-1:0] id_reg   [MAXN];
    logic [ID_W-1:0] id_next  [MAXN];
    logic [DW-1:0]   dist_reg [MAXN];
    logic [DW-1:0]   dist_next[MAXN];

    // compare flags
    logic [MAXN-1:0] gt_reg, gt_next;
    logic [MAXN-1:0] eq_reg, eq_next;
    logic            append_reg, append_next;

    // output register
    logic            m_valid_reg;
    logic [ID_W-1:0] m_id_reg;
    logic [DW-1:0]   m_dist_reg;
    logic            m_last_reg;
    logic            m_empty_reg;

    logic [CNT_W-1:0] k_eff;
    logic [CNT_W-1:0] held_dec;
    logic [IDX_W-1:0] last_idx;
    logic [MAXN-1:0]  valid;
    logic [MAXN-1:0]  upto_p;
    logic [MAXN-1:0]  region;
    logic [MAXN-1:0]  region_prev;
    logic [MAXN-1:0]  sel;
    logic             repl;
    logic             do_write;
    logic             seen;

    // clamp neighbor_count into 1..MAXN
    always_comb begin
        if (k_reg == '0) begin
            k_eff = CNT_W'(1);
        end else if (int'(k_reg) > MAXN) begin
            k_eff = CNT_W'(MAXN);
        end else begin
            k_eff = CNT_W'(k_reg);
        end
    end

    assign held_dec = held_reg - CNT_W'(1);
    assign last_idx = held_dec[IDX_W-1:0];

    // per-cell compares against the item and against the largest entry
    always_comb begin
        for (int i = 0; i < MAXN; i++) begin
            valid[i]   = CNT_W'(i) < held_reg;
            gt_next[i] = valid[i] && (dist_reg[i] > in_dist_reg);
            eq_next[i] = valid[i] && (dist_reg[i] == dist_reg[last_idx]);
        end
        append_next = held_reg < k_eff;
    end

    // cells in the shift region: from the insert point up to the eviction point
    always_comb begin
        seen = 1'b0;
        for (int i = 0; i < MAXN; i++) begin
            upto_p[i] = !seen;
            seen      = seen | eq_reg[i];
        end
        for (int i = 0; i < MAXN; i++) begin
            region[i] = gt_reg[i] && (append_reg || upto_p[i]);
            sel[i]    = region[i] || (append_reg && (CNT_W'(i) == held_reg));
        end
        region_prev = region << 1;
        repl        = !append_reg && (held_reg != '0) && gt_reg[last_idx];
        do_write    = cmd.update && (append_reg || repl);
    end

    // next cell contents
    always_comb begin
        for (int i = 0; i < MAXN; i++) begin
            id_next[i]   = id_reg[i];
            dist_next[i] = dist_reg[i];
        end
        if (do_write) begin
            for (int i = 0; i < MAXN; i++) begin
                if (sel[i]) begin
                    if (region_prev[i]) begin
                        id_next[i]   = id_reg[(i + MAXN - 1) % MAXN];
                        dist_next[i] = dist_reg[(i + MAXN - 1) % MAXN];
                    end else begin
                        id_next[i]   = in_id_reg;
                        dist_next[i] = in_dist_reg;
                    end
                end
            end
        end else if (cmd.emit_entry) begin
            for (int i = 0; i < MAXN - 1; i++) begin
                id_next[i]   = id_reg[i + 1];
                dist_next[i] = dist_reg[i + 1];
            end
        end
    end

    // count of held entries
    always_comb begin
        held_next = held_reg;
        if (do_write && append_reg) begin
            held_next = held_reg + CNT_W'(1);
        end else if (cmd.emit_entry) begin
            held_next = held_dec;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= knps_pkg::K_RESET;
            held_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                k_reg <= cfg_wdata;
            end
            held_reg <= held_next;
            if (cmd.emit_entry || cmd.emit_empty) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_id_reg   <= s_tdata[ID_W-1:0];
            in_dist_reg <= s_tdata[ID_W+DW-1:ID_W];
        end
        if (cmd.compare) begin
            gt_reg     <= gt_next;
            eq_reg     <= eq_next;
            append_reg <= append_next;
        end
        for (int i = 0; i < MAXN; i++) begin
            id_reg[i]   <= id_next[i];
            dist_reg[i] <= dist_next[i];
        end
        if (cmd.emit_entry) begin
            m_id_reg    <= id_reg[0];
            m_dist_reg  <= dist_reg[0];
            m_last_reg  <= (held_reg == CNT_W'(1));
            m_empty_reg <= 1'b0;
        end else if (cmd.emit_empty) begin
            m_id_reg    <= '0;
            m_dist_reg  <= '0;
            m_last_reg  <= 1'b1;
            m_empty_reg <= 1'b1;
        end
    end

    // status and outputs
    assign stat.held_zero = (held_reg == '0);
    assign stat.held_one  = (held_reg == CNT_W'(1));
    assign stat.out_free  = !m_valid_reg || m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_dist_reg, m_id_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_empty_reg;

endmodule

// File: hdl/knps_ctrl.sv
// ----------------------------------------------------------------------------
// knps_ctrl: sequencing of offer and finish items
// Offers run compare then update; a finish streams the held entries out one
// per free output slot, or a single empty marker.
// ----------------------------------------------------------------------------
module knps_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_op,
    output logic                  s_tready,
    input  knps_pkg::knps_stat_t  stat,
    output knps_pkg::knps_cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CMP   = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.capture = 1'b1;
                    if (s_op == knps_pkg::OP_FINISH) begin
                        state_next = stat.held_zero ? ST_EMPTY : ST_EMIT;
                    end else begin
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD: begin
                cmd.update = 1'b1;
                state_next = ST_IDLE;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit_entry = 1'b1;
                    if (stat.held_one) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMPTY: begin
                if (stat.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
